[rtl/core/ubd_pkg.sv]
// ----------------------------------------------------------------------------
// ubd_pkg
// Shared types, constants and helpers for the 256-bit binary to BCD converter.
// ----------------------------------------------------------------------------
package ubd_pkg;

   localparam int VALUE_BYTES_DEF = 32;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int LIMIT_W    = 7;

   typedef logic [LIMIT_W-1:0]    limit_type;
   typedef logic [CSR_ADDR_W-3:0] csr_index_type;

   localparam limit_type     LIMIT_RESET     = 7'd78;
   localparam csr_index_type REG_DIGIT_LIMIT = 1'b0;

   // digits valid in one result
   localparam logic [1:0] PAIR_NONE = 2'd0;
   localparam logic [1:0] PAIR_ONE  = 2'd1;
   localparam logic [1:0] PAIR_TWO  = 2'd2;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] digit_pair;
      logic [1:0] pair_count;
      logic       fail;
      logic       end_of_number;
   } rsp_type;

   // operations on the BCD digit row
   typedef enum logic [2:0] {
      BCD_HOLD,
      BCD_CLEAR,
      BCD_DABBLE,
      BCD_SHIFT1,
      BCD_SHIFT2
   } bcd_op_type;

   typedef struct packed {
      bcd_op_type op;
      logic       bit_in;
   } bcd_ctrl_type;

   // operations on the binary value shift register
   typedef enum logic [1:0] {
      VAL_HOLD,
      VAL_LOAD,
      VAL_SHIFT,
      VAL_CLEAR
   } val_op_type;

   // decimal digits needed for a value of the given byte count:
   // floor(bits * log10(2)) + 1, log10(2) taken as 1233/4096
   function automatic int ndig(input int bytes);
      return ((bytes * 8 * 1233) >> 12) + 1;
   endfunction

endpackage

[rtl/core/ubd_csr.sv]
// ----------------------------------------------------------------------------
// ubd_csr
// APB-style register slave holding the digit limit.
// ----------------------------------------------------------------------------
module ubd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ubd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ubd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ubd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output ubd_pkg::limit_type                digit_limit
);

   ubd_pkg::limit_type     digit_limit_ff;
   ubd_pkg::limit_type     digit_limit_in;
   ubd_pkg::csr_index_type reg_index;
   logic                   wr_en;

   // word index; the low two address bits are byte lanes
   assign reg_index = paddr[ubd_pkg::CSR_ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      digit_limit_in = digit_limit_ff;
      if (wr_en && (reg_index == ubd_pkg::REG_DIGIT_LIMIT)) begin
         digit_limit_in = pwdata[ubd_pkg::LIMIT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == ubd_pkg::REG_DIGIT_LIMIT) begin
         prdata = ubd_pkg::CSR_DATA_W'(digit_limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_limit_ff <= ubd_pkg::LIMIT_RESET;
      end else begin
         digit_limit_ff <= digit_limit_in;
      end
   end

   assign digit_limit = digit_limit_ff;

endmodule

[rtl/core/ubd_value_sr.sv]
// ----------------------------------------------------------------------------
// ubd_value_sr
// Binary value shift register: bytes enter at the bottom, bits leave at the
// top one per cycle during conversion.
// ----------------------------------------------------------------------------
module ubd_value_sr #(
   parameter int VALUE_BYTES = ubd_pkg::VALUE_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ubd_pkg::val_op_type op,
   input  logic [7:0]          byte_in,
   output logic                msb
);

   localparam int VALUE_W = VALUE_BYTES * 8;

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic [VALUE_W+7:0] loaded;

   assign loaded = {value_ff, byte_in};

   always_comb begin
      case (op)
         ubd_pkg::VAL_HOLD:  value_in = value_ff;
         ubd_pkg::VAL_LOAD:  value_in = loaded[VALUE_W-1:0];
         ubd_pkg::VAL_SHIFT: value_in = {value_ff[VALUE_W-2:0], 1'b0};
         ubd_pkg::VAL_CLEAR: value_in = '0;
         default:            value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign msb = value_ff[VALUE_W-1];

endmodule

[rtl/core/ubd_bcd_row.sv]
// ----------------------------------------------------------------------------
// ubd_bcd_row
// Row of BCD digit cells. Shift-and-add-3 takes one binary bit per cycle;
// afterwards the row shifts up one or two digits at a time to read out.
// ----------------------------------------------------------------------------
module ubd_bcd_row #(
   parameter int NDIG = 78
) (
   input  logic                  clock,
   input  ubd_pkg::bcd_ctrl_type ctrl,
   output logic [3:0]            top_digit,
   output logic [3:0]            next_digit
);

   logic [3:0] dig_ff [NDIG];
   logic [3:0] adj    [NDIG];
   logic       carry  [NDIG];
   logic [3:0] src1   [NDIG];
   logic [3:0] src2   [NDIG];

   for (genvar i = 0; i < NDIG; i++) begin : g_cell
      assign adj[i] = (dig_ff[i] >= 4'd5) ? (dig_ff[i] + 4'd3) : dig_ff[i];

      if (i == 0) begin : g_low
         assign carry[i] = ctrl.bit_in;
         assign src1[i]  = 4'd0;
         assign src2[i]  = 4'd0;
      end else if (i == 1) begin : g_second
         assign carry[i] = adj[i-1][3];
         assign src1[i]  = dig_ff[i-1];
         assign src2[i]  = 4'd0;
      end else begin : g_upper
         assign carry[i] = adj[i-1][3];
         assign src1[i]  = dig_ff[i-1];
         assign src2[i]  = dig_ff[i-2];
      end

      always_ff @(posedge clock) begin
         case (ctrl.op)
            ubd_pkg::BCD_CLEAR:  dig_ff[i] <= 4'd0;
            ubd_pkg::BCD_DABBLE: dig_ff[i] <= {adj[i][2:0], carry[i]};
            ubd_pkg::BCD_SHIFT1: dig_ff[i] <= src1[i];
            ubd_pkg::BCD_SHIFT2: dig_ff[i] <= src2[i];
            default:             dig_ff[i] <= dig_ff[i];
         endcase
      end
   end

   assign top_digit  = dig_ff[NDIG-1];
   assign next_digit = dig_ff[NDIG-2];

endmodule

[rtl/core/u256_binary_to_decimal.sv]
// ----------------------------------------------------------------------------
// u256_binary_to_decimal
// Unsigned big-endian binary number to packed BCD digits, bit-serial.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one byte of the number per item, most significant first;
//   final_byte marks the last byte and starts the conversion. Bytes are taken
//   at one a cycle while loading.
//   rsp channel: the decimal digits, most significant first, two per item;
//   an odd count puts the leading digit alone in the low nibble of the first
//   item. A number longer than VALUE_BYTES bytes, or with more digits than
//   digit_limit, gives a single item with fail set. end_of_number marks the
//   last item of each number.
//   Sequence: after the final byte, shift-and-add-3 runs over every bit of
//   the value (one bit a cycle through the digit row), then leading zero
//   digits are dropped one at a time (up to the row depth less one), the
//   limit is checked, then one item per cycle while the output is not
//   stalled. An overlong number goes straight to its fail item. req_stall
//   stays high from the final byte until the last item has entered the output register.
//   The output register holds a stalled item unchanged; conversion pauses in
//   read-out until it is taken. Reset clears the number, the byte count, the
//   output valid and sets digit_limit to 78.
// ----------------------------------------------------------------------------
module u256_binary_to_decimal #(
   parameter int VALUE_BYTES = ubd_pkg::VALUE_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ubd_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ubd_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ubd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ubd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ubd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int VALUE_W = VALUE_BYTES * 8;
   localparam int NDIG    = ubd_pkg::ndig(VALUE_BYTES);
   localparam int BSEEN_W = $clog2(VALUE_BYTES + 1);
   localparam int BIT_W   = $clog2(VALUE_W);
   localparam int DIG_W   = $clog2(NDIG + 1);

   typedef enum logic [1:0] {
      S_LOAD,
      S_CONV,
      S_SKIP,
      S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [BSEEN_W-1:0]    bytes_seen_ff, bytes_seen_in;
   logic                  overlong_ff, overlong_in;
   logic                  fail_ff, fail_in;
   logic [BIT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [DIG_W-1:0]      digits_ff, digits_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ubd_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   ubd_pkg::bcd_ctrl_type bcd_ctrl;
   ubd_pkg::val_op_type   val_op;
   ubd_pkg::limit_type    digit_limit;
   logic                  value_msb;
   logic [3:0]            top_digit;
   logic [3:0]            next_digit;
   logic                  req_fire;
   logic                  out_free;
   logic                  full;

   ubd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .digit_limit (digit_limit)
   );

   ubd_value_sr #(
      .VALUE_BYTES (VALUE_BYTES)
   ) u_value_sr (
      .clock   (clock),
      .reset   (reset),
      .op      (val_op),
      .byte_in (req_data.value_byte),
      .msb     (value_msb)
   );

   ubd_bcd_row #(
      .NDIG (NDIG)
   ) u_bcd_row (
      .clock      (clock),
      .ctrl       (bcd_ctrl),
      .top_digit  (top_digit),
      .next_digit (next_digit)
   );

   assign req_stall = (state_ff != S_LOAD);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (bytes_seen_ff == BSEEN_W'(VALUE_BYTES));

   always_comb begin
      state_in        = state_ff;
      bytes_seen_in   = bytes_seen_ff;
      overlong_in     = overlong_ff;
      fail_in         = fail_ff;
      bit_cnt_in      = bit_cnt_ff;
      digits_in       = digits_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      bcd_ctrl.op     = ubd_pkg::BCD_HOLD;
      bcd_ctrl.bit_in = value_msb;
      val_op          = ubd_pkg::VAL_HOLD;

      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  overlong_in = 1'b1;
               end else begin
                  val_op        = ubd_pkg::VAL_LOAD;
                  bytes_seen_in = bytes_seen_ff + BSEEN_W'(1);
               end
               if (req_data.final_byte) begin
                  bytes_seen_in = '0;
                  overlong_in   = 1'b0;
                  if (overlong_ff || full) begin
                     val_op   = ubd_pkg::VAL_CLEAR;
                     fail_in  = 1'b1;
                     state_in = S_EMIT;
                  end else begin
                     bcd_ctrl.op = ubd_pkg::BCD_CLEAR;
                     bit_cnt_in  = BIT_W'(VALUE_W - 1);
                     state_in    = S_CONV;
                  end
               end
            end
         end
         S_CONV: begin
            bcd_ctrl.op = ubd_pkg::BCD_DABBLE;
            val_op      = ubd_pkg::VAL_SHIFT;
            bit_cnt_in  = bit_cnt_ff - BIT_W'(1);
            if (bit_cnt_ff == '0) begin
               digits_in = DIG_W'(NDIG);
               state_in  = S_SKIP;
            end
         end
         S_SKIP: begin
            // drop leading zeros, keeping at least one digit
            if ((top_digit == 4'd0) && (digits_ff != DIG_W'(1))) begin
               bcd_ctrl.op = ubd_pkg::BCD_SHIFT1;
               digits_in   = digits_ff - DIG_W'(1);
            end else begin
               fail_in  = ubd_pkg::limit_type'(digits_ff) > digit_limit;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (fail_ff) begin
                  rsp_data_in.digit_pair    = 8'd0;
                  rsp_data_in.pair_count    = ubd_pkg::PAIR_NONE;
                  rsp_data_in.fail          = 1'b1;
                  rsp_data_in.end_of_number = 1'b1;
                  fail_in                   = 1'b0;
                  state_in                  = S_LOAD;
               end else if (digits_ff[0]) begin
                  rsp_data_in.digit_pair    = {4'd0, top_digit};
                  rsp_data_in.pair_count    = ubd_pkg::PAIR_ONE;
                  rsp_data_in.fail          = 1'b0;
                  rsp_data_in.end_of_number = (digits_ff == DIG_W'(1));
                  bcd_ctrl.op               = ubd_pkg::BCD_SHIFT1;
                  digits_in                 = digits_ff - DIG_W'(1);
                  if (digits_ff == DIG_W'(1)) begin
                     state_in = S_LOAD;
                  end
               end else begin
                  rsp_data_in.digit_pair    = {top_digit, next_digit};
                  rsp_data_in.pair_count    = ubd_pkg::PAIR_TWO;
                  rsp_data_in.fail          = 1'b0;
                  rsp_data_in.end_of_number = (digits_ff == DIG_W'(2));
                  bcd_ctrl.op               = ubd_pkg::BCD_SHIFT2;
                  digits_in                 = digits_ff - DIG_W'(2);
                  if (digits_ff == DIG_W'(2)) begin
                     state_in = S_LOAD;
                  end
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         bytes_seen_ff <= '0;
         overlong_ff   <= 1'b0;
         fail_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bytes_seen_ff <= bytes_seen_in;
         overlong_ff   <= overlong_in;
         fail_ff       <= fail_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      bit_cnt_ff  <= bit_cnt_in;
      digits_ff   <= digits_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/ubd_checker.sv]
// ----------------------------------------------------------------------------
// ubd_checker
// Port-level assertions for the binary to BCD converter, bound to the top.
// ----------------------------------------------------------------------------
module ubd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ubd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ubd_pkg::rsp_type rsp_data
);

   // output register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result item changed");

   // a final byte ends loading, so the input stalls next cycle
   a_final_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.final_byte) |=> req_stall)
      else $error("input not stalled after final byte");

   // while a number is being read out, no new bytes are taken
   a_mid_number_stalls: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.end_of_number) |-> req_stall)
      else $error("input taken in the middle of a number");

endmodule

bind u256_binary_to_decimal ubd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[dv/decimal_digit_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_digit_checker
// Watches the byte, digit and register ports of the binary to BCD converter.
// Rebuilds each number from the accepted bytes, works out the digit items it
// must produce under the current digit limit and checks every delivered item
// field by field against the oldest one due.
// ----------------------------------------------------------------------------
module decimal_digit_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  ubd_pkg::req_type                      req_data,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  ubd_pkg::rsp_type                      rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic                                  pready,
   input  logic [ubd_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [ubd_pkg::CSR_DATA_W-1:0]        pwdata,
   output int                                    error_count,
   output int                                    digits_pending,
   output int                                    numbers_seen,
   output int                                    numbers_rejected,
   output int                                    items_delivered
);

   localparam int MAX_DIGITS   = 78;
   localparam int NUMBER_BYTES = ubd_pkg::VALUE_BYTES_DEF;
   localparam logic [ubd_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR = {ubd_pkg::REG_DIGIT_LIMIT, 2'b00};

   ubd_pkg::limit_type digit_cap;
   logic [255:0]       number_acc;
   int                 bytes_taken;
   bit                 too_long;
   ubd_pkg::rsp_type   digits_due [$];
   ubd_pkg::rsp_type   want;
   int                 error_total;
   int                 number_total;
   int                 reject_total;
   int                 delivered_total;

   // Queue the digit items for one finished number, most significant first.
   function automatic void queue_digits(input logic [255:0] value, input bit overflowed);
      logic [255:0]     rest;
      logic [3:0]       digit_row [MAX_DIGITS];
      int               n_digits;
      int               pos;
      ubd_pkg::rsp_type item;
      rest     = value;
      n_digits = 0;
      if (!overflowed) begin
         // zero still yields a single digit
         do begin
            digit_row[n_digits] = 4'(rest % 10);
            rest = rest / 10;
            n_digits++;
         end while (rest != '0);
      end
      if (overflowed || n_digits > int'(digit_cap)) begin
         item = '{digit_pair: 8'h00, pair_count: ubd_pkg::PAIR_NONE, fail: 1'b1,
                  end_of_number: 1'b1};
         digits_due.push_back(item);
         reject_total++;
      end else begin
         pos = n_digits - 1;
         if (n_digits % 2 == 1) begin
            // leading digit goes alone in the low nibble
            item = '{digit_pair: {4'h0, digit_row[pos]}, pair_count: ubd_pkg::PAIR_ONE,
                     fail: 1'b0, end_of_number: (pos == 0)};
            digits_due.push_back(item);
            pos--;
         end
         while (pos >= 1) begin
            item = '{digit_pair: {digit_row[pos], digit_row[pos-1]},
                     pair_count: ubd_pkg::PAIR_TWO,
                     fail: 1'b0, end_of_number: (pos == 1)};
            digits_due.push_back(item);
            pos -= 2;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         digit_cap       = ubd_pkg::LIMIT_RESET;
         number_acc      = '0;
         bytes_taken     = 0;
         too_long        = 1'b0;
         digits_due.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) begin
            digit_cap = pwdata[ubd_pkg::LIMIT_W-1:0];
         end
         if (req_valid && !req_stall) begin
            if (bytes_taken < NUMBER_BYTES) begin
               number_acc = {number_acc[247:0], req_data.value_byte};
               bytes_taken++;
            end else begin
               too_long = 1'b1;
            end
            if (req_data.final_byte) begin
               queue_digits(number_acc, too_long);
               number_acc  = '0;
               bytes_taken = 0;
               too_long    = 1'b0;
               number_total++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            delivered_total++;
            if (digits_due.size() == 0) begin
               error_total++;
               if (error_total <= 10) begin
                  $display("%0t: digit item with nothing due: pair=%h count=%0d fail=%b end=%b",
                           $realtime, rsp_data.digit_pair, rsp_data.pair_count,
                           rsp_data.fail, rsp_data.end_of_number);
               end
            end else begin
               want = digits_due.pop_front();
               if (rsp_data.digit_pair !== want.digit_pair ||
                   rsp_data.pair_count !== want.pair_count ||
                   rsp_data.fail !== want.fail ||
                   rsp_data.end_of_number !== want.end_of_number) begin
                  error_total++;
                  if (error_total <= 10) begin
                     $display("%0t: digit item mismatch: expected pair=%h count=%0d fail=%b end=%b",
                              $realtime, want.digit_pair, want.pair_count, want.fail,
                              want.end_of_number);
                     $display("%0t:                        actual pair=%h count=%0d fail=%b end=%b",
                              $realtime, rsp_data.digit_pair, rsp_data.pair_count,
                              rsp_data.fail, rsp_data.end_of_number);
                  end
               end
            end
         end
      end
      error_count      <= error_total;
      digits_pending   <= digits_due.size();
      numbers_seen     <= number_total;
      numbers_rejected <= reject_total;
      items_delivered  <= delivered_total;
   end

endmodule

[dv/tb_u256_binary_to_decimal.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_u256_binary_to_decimal
// Stimulus and verdict for the 256-bit binary to BCD converter.
// Drives numbers byte by byte under several digit limits, with random gaps on
// the byte side and random stalls on the digit side; the checker instance
// predicts and compares every digit item.
// ----------------------------------------------------------------------------
module tb_u256_binary_to_decimal;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 400;
   localparam int PHASE_ITEMS   = 60;
   localparam logic [ubd_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR = {ubd_pkg::REG_DIGIT_LIMIT, 2'b00};

   typedef enum int {
      FILL_RANDOM,
      FILL_ONES,
      FILL_ZERO,
      FILL_SPARSE
   } fill_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   ubd_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   ubd_pkg::rsp_type               rsp_data;
   logic                           psel      = 1'b0;
   logic                           penable   = 1'b0;
   logic                           pwrite    = 1'b0;
   logic [ubd_pkg::CSR_ADDR_W-1:0] paddr     = '0;
   logic [ubd_pkg::CSR_DATA_W-1:0] pwdata    = '0;
   logic [ubd_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int bytes_sent     = 0;
   int mid_limit;
   int cycle_count;
   int error_count;
   int digits_pending;
   int numbers_seen;
   int numbers_rejected;
   int items_delivered;

   u256_binary_to_decimal i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   decimal_digit_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .error_count      (error_count),
      .digits_pending   (digits_pending),
      .numbers_seen     (numbers_seen),
      .numbers_rejected (numbers_rejected),
      .items_delivered  (items_delivered)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic push_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{value_byte: value, final_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_number(input fill_type style, input int nbytes);
      logic [7:0] value;
      for (int i = 0; i < nbytes; i++) begin
         case (style)
            FILL_ONES:   value = 8'hFF;
            FILL_ZERO:   value = 8'h00;
            FILL_SPARSE: value = (i < nbytes / 2) ? 8'h00 : 8'($urandom);
            default:     value = 8'($urandom);
         endcase
         push_byte(value, i == nbytes - 1);
      end
   endtask

   // hold the byte side until every digit item due has been delivered
   task automatic settle(input bit with_tail);
      req_valid <= 1'b0;
      @(posedge clock);
      while (digits_pending != 0) @(posedge clock);
      if (with_tail) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LIMIT_ADDR;
      pwdata  <= {25'($urandom), 7'(value)};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int gap_pct, input int stall_pct, input int limit);
      int pick;
      int target;
      write_limit(limit);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      target = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_number(FILL_RANDOM, ($urandom_range(3) == 0) ? $urandom_range(17, 32)
                                                               : $urandom_range(1, 16));
         end else if (pick < 62) begin
            send_number(FILL_ONES, ($urandom_range(1) == 0) ? 32 : $urandom_range(1, 31));
         end else if (pick < 70) begin
            send_number(FILL_ZERO, $urandom_range(1, 6));
         end else if (pick < 85) begin
            send_number(FILL_SPARSE, $urandom_range(2, 32));
         end else if (pick < 93) begin
            // more bytes than the value register holds
            send_number(FILL_RANDOM, $urandom_range(33, 36));
         end else begin
            send_number(FILL_RANDOM, $urandom_range(1, 4));
         end
         if ($urandom_range(9) == 0) settle(1'b0);
      end
      settle(1'b1);
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped: no completion within %0d cycles", CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limit of 78: zero, odd and even digit counts, leading zero bytes
      send_gap_pct   = 15;
      recv_stall_pct = 65;
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h63, 1'b1);
      push_byte(8'h0A, 1'b1);
      send_number(FILL_ZERO, 2);
      push_byte(8'h01, 1'b0);
      push_byte(8'h00, 1'b1);
      settle(1'b1);

      // a zero limit rejects even the value zero
      write_limit(0);
      push_byte(8'h00, 1'b1);
      settle(1'b1);

      write_limit(1);
      push_byte(8'h09, 1'b1);
      push_byte(8'h0A, 1'b1);
      settle(1'b1);

      write_limit(2);
      push_byte(8'h63, 1'b1);
      push_byte(8'hFF, 1'b1);
      settle(1'b1);

      // largest value and an overlong number at the full limit
      write_limit(78);
      send_number(FILL_ONES, 32);
      send_number(FILL_RANDOM, 33);
      settle(1'b1);

      mid_limit = $urandom_range(20, 60);
      run_phase(15, 65, 78);
      run_phase(65, 15, mid_limit);
      run_phase(0, 0, 127);

      $display("Sent %0d bytes forming %0d numbers under limits 78, 0, 1, 2, %0d and 127;",
               bytes_sent, numbers_seen, mid_limit);
      $display("%0d numbers rejected, %0d digit items delivered and checked",
               numbers_rejected, items_delivered);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
